[rtl/fpd_pkg.sv]
// ----------------------------------------------------------------------------
// fpd_pkg
// Types and constants shared by the framed packet deframer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package fpd_pkg;

  // Configuration port geometry
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  // Register indexes (byte address is 4 * index)
  localparam logic [2:0] REG_START_BYTE  = 3'd0;
  localparam logic [2:0] REG_END_BYTE    = 3'd1;
  localparam logic [2:0] REG_START_COUNT = 3'd2;
  localparam logic [2:0] REG_END_COUNT   = 3'd3;
  localparam logic [2:0] REG_MAX_LENGTH  = 3'd4;

  // Register reset values
  localparam logic [7:0] RST_START_BYTE  = 8'd2;
  localparam logic [7:0] RST_END_BYTE    = 8'd3;
  localparam logic [2:0] RST_START_COUNT = 3'd2;
  localparam logic [2:0] RST_END_COUNT   = 3'd2;
  localparam logic [5:0] RST_MAX_LENGTH  = 6'd32;

  // Most results one packet may produce
  localparam int RESULT_CAP = 32;

  // Request codes
  localparam logic REQ_BYTE = 1'b0;
  localparam logic REQ_IDLE = 1'b1;

  typedef struct packed {
    logic       req_type;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] command;
    logic [5:0] length;
    logic [4:0] index;
    logic [7:0] payload_byte;
    logic       has_data;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic [7:0] start_byte;
    logic [7:0] end_byte;
    logic [2:0] start_count;
    logic [2:0] end_count;
    logic [5:0] max_length;
  } cfg_t;

  typedef enum logic [2:0] {
    PH_START,
    PH_CMD,
    PH_LEN,
    PH_DATA,
    PH_END,
    PH_DISCARD,
    PH_READ,
    PH_SHOW
  } phase_t;

  // Controller to datapath
  typedef struct packed {
    logic delim_clr;
    logic delim_inc;
    logic cmd_load;
    logic len_load;
    logic data_wr;
    logic run_start;
    logic run_adv;
    logic rd_en;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic start_match;
    logic end_match;
    logic start_zero;
    logic end_zero;
    logic start_reached;
    logic end_reached;
    logic len_ok;
    logic len_zero;
    logic data_done;
    logic hold_zero;
    logic run_end;
  } dp_stat_t;

endpackage

`default_nettype wire

[rtl/fpd_dp.sv]
// ----------------------------------------------------------------------------
// fpd_dp
// Datapath: delimiter counter, command and length holds, payload buffer and
// result run counter with registered buffer read.
// ----------------------------------------------------------------------------
`default_nettype none

module fpd_dp
  import fpd_pkg::*;
#(
  parameter int DATA_SIZE = 32
) (
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  logic [7:0] rx_byte,
  input  dp_cmd_t   cmd,
  output dp_stat_t  stat,
  output out_item_t result
);

  localparam int AW = (DATA_SIZE > 1) ? $clog2(DATA_SIZE) : 1;
  localparam int CAP = (DATA_SIZE < RESULT_CAP) ? DATA_SIZE : RESULT_CAP;
  localparam logic [5:0] CAP_LEN = 6'(CAP);

  logic [2:0]  delim_count;
  logic [7:0]  cmd_hold;
  logic [5:0]  len_hold;
  logic [5:0]  data_index;
  logic [4:0]  run_index;
  logic [7:0]  rd_data;
  logic [7:0]  payload_mem [DATA_SIZE];

  logic [2:0]  delim_inc_val;
  logic [5:0]  limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      delim_count <= '0;
      data_index  <= '0;
      run_index   <= '0;
    end else begin
      if (cmd.delim_clr) begin
        delim_count <= '0;
      end else if (cmd.delim_inc) begin
        delim_count <= delim_inc_val;
      end
      if (cmd.len_load) begin
        data_index <= '0;
      end else if (cmd.data_wr) begin
        data_index <= data_index + 6'd1;
      end
      if (cmd.run_start) begin
        run_index <= '0;
      end else if (cmd.run_adv) begin
        run_index <= run_index + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_hold <= '0;
      len_hold <= '0;
    end else begin
      if (cmd.cmd_load) begin
        cmd_hold <= rx_byte;
      end
      if (cmd.len_load) begin
        len_hold <= rx_byte[5:0];
      end
    end
  end

  // Payload buffer: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.data_wr) begin
      payload_mem[AW'(data_index)] <= rx_byte;
    end
    if (cmd.rd_en) begin
      rd_data <= payload_mem[AW'(run_index)];
    end
  end

  always_comb begin
    delim_inc_val = delim_count + 3'd1;
    limit         = (cfg.max_length > CAP_LEN) ? CAP_LEN : cfg.max_length;

    stat.start_match   = (rx_byte == cfg.start_byte);
    stat.end_match     = (rx_byte == cfg.end_byte);
    stat.start_zero    = (cfg.start_count == 3'd0);
    stat.end_zero      = (cfg.end_count == 3'd0);
    stat.start_reached = (delim_inc_val >= cfg.start_count);
    stat.end_reached   = (delim_inc_val >= cfg.end_count);
    stat.len_ok        = (rx_byte <= {2'b00, limit});
    stat.len_zero      = (rx_byte == 8'd0);
    stat.data_done     = ((data_index + 6'd1) >= len_hold);
    stat.hold_zero     = (len_hold == 6'd0);
    stat.run_end       = stat.hold_zero || (({1'b0, run_index} + 6'd1) == len_hold);

    result.command      = cmd_hold;
    result.length       = len_hold;
    result.index        = stat.hold_zero ? 5'd0 : run_index;
    result.payload_byte = stat.hold_zero ? 8'd0 : rd_data;
    result.has_data     = !stat.hold_zero;
    result.last         = stat.run_end;
  end

endmodule

`default_nettype wire

[rtl/fpd_ctrl.sv]
// ----------------------------------------------------------------------------
// fpd_ctrl
// Controller: frame parsing state machine and result run sequencing.
// ----------------------------------------------------------------------------
`default_nettype none

module fpd_ctrl
  import fpd_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  logic     req_type,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output logic     in_ready,
  output logic     out_valid,
  output dp_cmd_t  cmd
);

  phase_t phase, phase_next;
  logic   take;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_START;
    end else begin
      phase <= phase_next;
    end
  end

  always_comb begin
    phase_next = phase;
    cmd        = '0;
    in_ready   = (phase != PH_READ) && (phase != PH_SHOW);
    out_valid  = (phase == PH_SHOW);
    take       = in_valid && in_ready;

    if (take && (req_type == REQ_IDLE)) begin
      // Abort whatever is in progress
      cmd.delim_clr = 1'b1;
      phase_next    = PH_START;
    end else begin
      case (phase)
        PH_START: begin
          if (take) begin
            if (stat.start_zero) begin
              cmd.cmd_load = 1'b1;
              phase_next   = PH_LEN;
            end else if (!stat.start_match) begin
              phase_next = PH_DISCARD;
            end else if (stat.start_reached) begin
              cmd.delim_clr = 1'b1;
              phase_next    = PH_CMD;
            end else begin
              cmd.delim_inc = 1'b1;
            end
          end
        end
        PH_CMD: begin
          if (take) begin
            cmd.cmd_load = 1'b1;
            phase_next   = PH_LEN;
          end
        end
        PH_LEN: begin
          if (take) begin
            if (!stat.len_ok) begin
              phase_next = PH_DISCARD;
            end else begin
              cmd.len_load = 1'b1;
              if (!stat.len_zero) begin
                phase_next = PH_DATA;
              end else if (stat.end_zero) begin
                cmd.delim_clr = 1'b1;
                cmd.run_start = 1'b1;
                phase_next    = PH_SHOW;
              end else begin
                cmd.delim_clr = 1'b1;
                phase_next    = PH_END;
              end
            end
          end
        end
        PH_DATA: begin
          if (take) begin
            cmd.data_wr = 1'b1;
            if (stat.data_done) begin
              cmd.delim_clr = 1'b1;
              if (stat.end_zero) begin
                cmd.run_start = 1'b1;
                phase_next    = PH_READ;
              end else begin
                phase_next = PH_END;
              end
            end
          end
        end
        PH_END: begin
          if (take) begin
            if (!stat.end_match) begin
              phase_next = PH_DISCARD;
            end else if (stat.end_reached) begin
              cmd.delim_clr = 1'b1;
              cmd.run_start = 1'b1;
              phase_next    = stat.hold_zero ? PH_SHOW : PH_READ;
            end else begin
              cmd.delim_inc = 1'b1;
            end
          end
        end
        PH_DISCARD: begin
          phase_next = PH_DISCARD;
        end
        PH_READ: begin
          cmd.rd_en  = 1'b1;
          phase_next = PH_SHOW;
        end
        PH_SHOW: begin
          if (out_ready) begin
            if (stat.run_end) begin
              phase_next = PH_START;
            end else begin
              cmd.run_adv = 1'b1;
              phase_next  = PH_READ;
            end
          end
        end
        default: begin
          phase_next = PH_START;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/framed_packet_deframer.sv]
// ----------------------------------------------------------------------------
// framed_packet_deframer
// Deframes start/end delimited, length prefixed packets from a byte stream.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready/in_data): one transaction per received byte
// or per line-idle event. Output channel (out_valid/out_ready/out_data): one
// transaction per payload byte of a good packet, or a single transaction with
// has_data low for an empty packet; last marks the end of the run.
// Configuration goes through the APB port; registers sit at 4 * index.
// While parsing, in_ready stays high and input transactions are taken as they
// come. After the closing delimiter the block emits the run from the payload
// buffer, each result of a nonempty packet through a buffer read and then a
// present step, set by the single registered read port. For an empty packet
// the first result shows in the cycle after the final byte.
// in_ready is low for the whole run. When the receiver stalls, the current
// result holds on out_data until taken. Reset returns registers to their
// defaults and the parser to hunting for the first start byte. Malformed
// packets are dropped until the next line-idle event.
// ----------------------------------------------------------------------------
`default_nettype none

module framed_packet_deframer
  import fpd_pkg::*;
#(
  parameter int DATA_SIZE = 32
) (
  input  logic              clk,
  input  logic              rst,
  // input byte stream
  input  logic              in_valid,
  output logic              in_ready,
  input  in_item_t          in_data,
  // result stream
  output logic              out_valid,
  input  logic              out_ready,
  output out_item_t         out_data,
  // configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  cfg_t     cfg;
  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     cfg_wr;
  logic [2:0] reg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_sel = paddr[4:2];

  // Register file: write on the access phase, ignore unknown addresses
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_byte  <= RST_START_BYTE;
      cfg.end_byte    <= RST_END_BYTE;
      cfg.start_count <= RST_START_COUNT;
      cfg.end_count   <= RST_END_COUNT;
      cfg.max_length  <= RST_MAX_LENGTH;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_START_BYTE:  cfg.start_byte  <= pwdata[7:0];
        REG_END_BYTE:    cfg.end_byte    <= pwdata[7:0];
        REG_START_COUNT: cfg.start_count <= pwdata[2:0];
        REG_END_COUNT:   cfg.end_count   <= pwdata[2:0];
        REG_MAX_LENGTH:  cfg.max_length  <= pwdata[5:0];
        default: begin
        end
      endcase
    end
  end

  // Read back, zero-extended
  always_comb begin
    case (reg_sel)
      REG_START_BYTE:  prdata = {24'd0, cfg.start_byte};
      REG_END_BYTE:    prdata = {24'd0, cfg.end_byte};
      REG_START_COUNT: prdata = {29'd0, cfg.start_count};
      REG_END_COUNT:   prdata = {29'd0, cfg.end_count};
      REG_MAX_LENGTH:  prdata = {26'd0, cfg.max_length};
      default:         prdata = '0;
    endcase
  end

  fpd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .req_type  (in_data.req_type),
    .out_ready (out_ready),
    .stat      (stat),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  fpd_dp #(
    .DATA_SIZE (DATA_SIZE)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .rx_byte (in_data.rx_byte),
    .cmd     (cmd),
    .stat    (stat),
    .result  (out_data)
  );

  // Never take input while a result is on offer
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input taken during result run");

  // Final result of a run hands control back to the parser
  a_last_resumes: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && out_data.last |=> in_ready && !out_valid)
    else $error("parser did not resume after last result");

  // A non-final result is followed by a buffer read cycle
  a_mid_run_read: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !out_data.last |=> !out_valid && !in_ready)
    else $error("missing buffer read between results");

  // Line-idle event leaves the parser ready
  a_idle_ready: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (in_data.req_type == REQ_IDLE) |=> in_ready)
    else $error("idle event did not return to hunting");

endmodule

`default_nettype wire

[tb/sv/tb_framed_packet_deframer.sv]
// ----------------------------------------------------------------------------
// tb_framed_packet_deframer
// Self-checking bench for the framed packet deframer: queued byte and
// line-idle transactions go in through a valid/ready driver, and a shadow
// parser predicts every result. A monitor checks each result field by field.
// Delimiter values, delimiter run lengths and the length limit change
// between phases over the APB port, under varied idle and stall patterns.
// ----------------------------------------------------------------------------
module tb_framed_packet_deframer;
  timeunit 1ns;
  timeprecision 1ps;

  import fpd_pkg::*;

  localparam int PAYLOAD_DEPTH = 32;     // DATA_SIZE of the instance
  localparam int SETTLE_CYCLES = 80;     // settle time once both queues are empty
  localparam int HOLD_CYCLES   = 300;    // long receiver hold-off
  localparam int PHASE_ITEMS   = 28;     // least random transactions queued per phase
  localparam int TIMEOUT_NS    = 2_000_000;

  typedef enum {FLOW_FREE, SRC_SPARSE, SINK_SLOW, BOTH_SLOW} traffic_t;
  typedef enum {FLAW_NONE, FLAW_START, FLAW_END, FLAW_LENGTH, FLAW_CUT} flaw_t;

  // Clock, reset and block ports
  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  in_item_t          in_data = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  out_item_t         out_data;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  // Stimulus queue and predicted results
  in_item_t  rx_event_q[$];
  out_item_t deframed_q[$];
  out_item_t want;

  // Shadow parser state and the register copy it works from
  cfg_t       shadow_cfg;
  phase_t     rx_phase = PH_START;
  logic [2:0] delim_seen = '0;
  logic [7:0] cmd_seen = '0;
  logic [5:0] len_seen = '0;
  logic [5:0] byte_pos = '0;
  logic [7:0] payload_mem [PAYLOAD_DEPTH];

  // Traffic shaping
  traffic_t traffic_mode = FLOW_FREE;
  logic     hold_armed = 1'b0;
  logic     hold_served = 1'b0;
  int       hold_left = 0;

  // Run statistics
  int mismatches = 0;
  int results_checked = 0;
  int good_packets = 0;
  int events_taken = 0;
  int settings_used = 0;

  framed_packet_deframer #(
    .DATA_SIZE(PAYLOAD_DEPTH)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Shadow parser
  // --------------------------------------------------------------------------

  // Effective length limit: max_length capped by the buffer and the run size.
  function automatic int length_cap();
    int cap;
    cap = shadow_cfg.max_length;
    if (cap > PAYLOAD_DEPTH) cap = PAYLOAD_DEPTH;
    if (cap > RESULT_CAP) cap = RESULT_CAP;
    return cap;
  endfunction

  function automatic cfg_t settings_of(input logic [7:0] sb, input logic [7:0] eb,
                                       input logic [2:0] sc, input logic [2:0] ec,
                                       input logic [5:0] ml);
    return {sb, eb, sc, ec, ml};
  endfunction

  function automatic string describe_result(input out_item_t r);
    return $sformatf("cmd=%h len=%0d idx=%0d byte=%h data=%b last=%b",
                     r.command, r.length, r.index, r.payload_byte, r.has_data, r.last);
  endfunction

  // Queue the run of a completed packet and go back to hunting.
  task automatic emit_run();
    out_item_t r;
    rx_phase = PH_START;
    delim_seen = '0;
    good_packets++;
    if (len_seen == 0) begin
      r = {cmd_seen, 6'd0, 5'd0, 8'd0, 1'b0, 1'b1};
      deframed_q.push_back(r);
    end else begin
      for (int k = 0; k < len_seen; k++) begin
        r.command      = cmd_seen;
        r.length       = len_seen;
        r.index        = 5'(k);
        r.payload_byte = payload_mem[k];
        r.has_data     = 1'b1;
        r.last         = (k == len_seen - 1);
        deframed_q.push_back(r);
      end
    end
  endtask

  // Payload is in: close at once when no end run is configured.
  task automatic finish_payload();
    delim_seen = '0;
    if (shadow_cfg.end_count == 0) emit_run();
    else rx_phase = PH_END;
  endtask

  // Advance the shadow parser by one accepted transaction.
  task automatic deframe_event(input in_item_t ev);
    logic [7:0] b;
    if (ev.req_type == REQ_IDLE) begin
      rx_phase = PH_START;
      delim_seen = '0;
      return;
    end
    b = ev.rx_byte;
    if (rx_phase == PH_START && shadow_cfg.start_count != 0) begin
      if (b != shadow_cfg.start_byte) begin
        rx_phase = PH_DISCARD;
      end else begin
        delim_seen = delim_seen + 3'd1;
        if (delim_seen >= shadow_cfg.start_count) begin
          rx_phase = PH_CMD;
          delim_seen = '0;
        end
      end
      return;
    end
    // No opening run: this byte is already the command.
    if (rx_phase == PH_START) rx_phase = PH_CMD;
    case (rx_phase)
      PH_CMD: begin
        cmd_seen = b;
        rx_phase = PH_LEN;
      end
      PH_LEN: begin
        if (b > length_cap()) begin
          rx_phase = PH_DISCARD;
        end else begin
          len_seen = b[5:0];
          byte_pos = '0;
          if (b == 0) finish_payload();
          else rx_phase = PH_DATA;
        end
      end
      PH_DATA: begin
        payload_mem[byte_pos[4:0]] = b;
        byte_pos = byte_pos + 6'd1;
        if (byte_pos >= len_seen) finish_payload();
      end
      PH_END: begin
        if (b != shadow_cfg.end_byte) begin
          rx_phase = PH_DISCARD;
        end else begin
          delim_seen = delim_seen + 3'd1;
          if (delim_seen >= shadow_cfg.end_count) emit_run();
        end
      end
      default: ;
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Driver: present queued transactions, predict each one as it is accepted
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      in_valid   <= 1'b0;
      in_data    <= '0;
      rx_phase   = PH_START;
      delim_seen = '0;
      cmd_seen   = '0;
      len_seen   = '0;
      byte_pos   = '0;
    end else begin
      if (in_valid && in_ready) begin
        deframe_event(in_data);
        events_taken++;
      end
      // Hold the payload while a transaction is still waiting for ready.
      if (!in_valid || in_ready) begin
        if (rx_event_q.size() != 0 &&
            !((traffic_mode == SRC_SPARSE && $urandom_range(0, 99) < 65) ||
              (traffic_mode == BOTH_SLOW && $urandom_range(0, 99) < 23))) begin
          in_valid <= 1'b1;
          in_data  <= rx_event_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Long receiver hold-off, counted here so the sender keeps offering input
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      hold_left   <= 0;
      hold_served <= 1'b0;
    end else if (hold_armed && !hold_served) begin
      hold_left   <= HOLD_CYCLES;
      hold_served <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: check each accepted result against the oldest prediction
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (deframed_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, expected none, actual %s",
                   $time, describe_result(out_data));
        end else begin
          want = deframed_q.pop_front();
          results_checked++;
          if (out_data.command !== want.command || out_data.length !== want.length ||
              out_data.index !== want.index || out_data.payload_byte !== want.payload_byte ||
              out_data.has_data !== want.has_data || out_data.last !== want.last) begin
            mismatches++;
            $display("%0t: result mismatch, expected %s, actual %s",
                     $time, describe_result(want), describe_result(out_data));
          end
        end
      end
      out_ready <= (hold_left == 0) &&
                   !((traffic_mode == SINK_SLOW && $urandom_range(0, 99) < 65) ||
                     (traffic_mode == BOTH_SLOW && $urandom_range(0, 99) < 23));
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Write one register: setup cycle, then access cycle until pready.
  task automatic reg_write(input logic [2:0] idx, input logic [7:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Program all registers; the block is idle whenever this runs.
  task automatic apply_settings(input cfg_t c);
    reg_write(REG_START_BYTE, c.start_byte);
    reg_write(REG_END_BYTE, c.end_byte);
    reg_write(REG_START_COUNT, {5'd0, c.start_count});
    reg_write(REG_END_COUNT, {5'd0, c.end_count});
    reg_write(REG_MAX_LENGTH, {2'd0, c.max_length});
    shadow_cfg = c;
    settings_used++;
  endtask

  task automatic push_idle();
    rx_event_q.push_back({REQ_IDLE, 8'($urandom)});
  endtask

  // Queue one packet under the current settings, optionally broken. Broken
  // packets end in an idle event so the parser resynchronizes.
  task automatic push_packet(input logic [7:0] cmd, input int len, input flaw_t flaw);
    logic [7:0] frame[$];
    int         pick;
    if ((flaw == FLAW_START && shadow_cfg.start_count == 0) ||
        (flaw == FLAW_END && shadow_cfg.end_count == 0)) flaw = FLAW_LENGTH;
    repeat (shadow_cfg.start_count) frame.push_back(shadow_cfg.start_byte);
    frame.push_back(cmd);
    if (flaw == FLAW_LENGTH) begin
      // Over-long length: the rest of the frame is discarded anyway.
      frame.push_back(8'($urandom_range(length_cap() + 1, 255)));
    end else begin
      frame.push_back(8'(len));
      repeat (len) frame.push_back(8'($urandom));
      repeat (shadow_cfg.end_count) frame.push_back(shadow_cfg.end_byte);
    end
    case (flaw)
      FLAW_START: begin
        pick = $urandom_range(0, shadow_cfg.start_count - 1);
        frame[pick] = frame[pick] ^ 8'($urandom_range(1, 255));
      end
      FLAW_END: begin
        pick = frame.size() - 1 - $urandom_range(0, shadow_cfg.end_count - 1);
        frame[pick] = frame[pick] ^ 8'($urandom_range(1, 255));
      end
      FLAW_CUT: begin
        // Drop the tail: the idle event lands in mid-packet.
        pick = $urandom_range(1, frame.size() - 1);
        while (frame.size() > pick) void'(frame.pop_back());
      end
      default: ;
    endcase
    foreach (frame[i]) rx_event_q.push_back({REQ_BYTE, frame[i]});
    if (flaw != FLAW_NONE) begin
      if (flaw != FLAW_CUT)
        repeat ($urandom_range(0, 2)) rx_event_q.push_back({REQ_BYTE, 8'($urandom)});
      push_idle();
    end
  endtask

  // Wait until every transaction is taken and every result has arrived.
  task automatic wait_quiet();
    do @(negedge clk);
    while (rx_event_q.size() != 0 || in_valid || deframed_q.size() != 0 || hold_left != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One random phase: mostly good packets with random content, the rest
  // broken packets and noise. Under pressure, only mid-sized good packets.
  // The full-length packet goes out once, in the phase that stalls both sides.
  task automatic random_phase(input traffic_t mode, input bit pressure);
    int roll;
    int cap;
    int base;
    @(negedge clk);
    traffic_mode = mode;
    cap = length_cap();
    if (pressure) hold_armed = 1'b1;
    if (cap == PAYLOAD_DEPTH && mode == BOTH_SLOW) push_packet(8'($urandom), cap, FLAW_NONE);
    base = rx_event_q.size();
    while (rx_event_q.size() < base + PHASE_ITEMS) begin
      roll = $urandom_range(0, 99);
      if (pressure) begin
        push_packet(8'($urandom), $urandom_range(4, cap < 12 ? cap : 12), FLAW_NONE);
      end else if (roll < 70) begin
        // Favor short payloads; now and then anything up to the limit.
        push_packet(8'($urandom),
                    ($urandom_range(0, 3) != 0) ? $urandom_range(0, cap < 6 ? cap : 6)
                                                : $urandom_range(0, cap),
                    FLAW_NONE);
      end else if (roll < 88) begin
        push_packet(8'($urandom), $urandom_range(0, cap),
                    flaw_t'($urandom_range(FLAW_START, FLAW_CUT)));
      end else begin
        repeat ($urandom_range(1, 4)) rx_event_q.push_back(in_item_t'(9'($urandom)));
        push_idle();
      end
    end
    wait_quiet();
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    shadow_cfg = {RST_START_BYTE, RST_END_BYTE, RST_START_COUNT, RST_END_COUNT,
                  RST_MAX_LENGTH};
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed, reset settings: a one-byte packet, a wrong closing byte,
    // and an idle event in mid-packet.
    @(negedge clk);
    push_packet(8'hFF, 1, FLAW_NONE);
    push_packet(8'h44, 0, FLAW_END);
    push_packet(8'h33, 2, FLAW_CUT);
    wait_quiet();

    // Directed, no delimiters and a zero length limit: an empty packet is
    // two bytes, and any nonzero length is over-long.
    apply_settings(settings_of(RST_START_BYTE, RST_END_BYTE, 3'd0, 3'd0, 6'd0));
    @(negedge clk);
    push_packet(8'h00, 0, FLAW_NONE);
    push_packet(8'h7E, 0, FLAW_LENGTH);
    wait_quiet();

    // Random phases under changing settings and traffic patterns.
    apply_settings(settings_of(8'($urandom), 8'($urandom), 3'($urandom_range(1, 4)),
                               3'($urandom_range(1, 4)), 6'd32));
    random_phase(FLOW_FREE, 1'b0);
    apply_settings(settings_of(8'($urandom), 8'($urandom), 3'd4, 3'd4, 6'd32));
    random_phase(SRC_SPARSE, 1'b0);
    apply_settings(settings_of(8'($urandom), 8'($urandom), 3'd1, 3'd1,
                               6'($urandom_range(1, 12))));
    random_phase(SINK_SLOW, 1'b0);
    // Delimiter runs longer than four, limit register above the cap.
    apply_settings(settings_of(8'($urandom), 8'($urandom), 3'd7, 3'd5, 6'd63));
    random_phase(BOTH_SLOW, 1'b0);
    // Stall the receiver for a long stretch so the input backs up.
    apply_settings(settings_of(8'h00, 8'hFF, 3'd3, 3'd2, 6'd16));
    random_phase(FLOW_FREE, 1'b1);

    $display("Run covered %0d input transactions and %0d good packets, %0d results checked",
             events_taken, good_packets, results_checked);
    $display("over %0d register settings, with free flow, sparse input and stalled output",
             settings_used);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Stop a hung run.
  initial begin
    #(TIMEOUT_NS);
    $display("Timeout with %0d results still expected", deframed_q.size());
    $display("FAILURE");
    $finish;
  end

endmodule

[files.f]
rtl/fpd_pkg.sv
rtl/fpd_dp.sv
rtl/fpd_ctrl.sv
rtl/framed_packet_deframer.sv
tb/sv/tb_framed_packet_deframer.sv
